[rtl/assert_macros.svh]
// Assertion macros used by the top level of the matrix engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked on every rising edge out of reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge out of reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/mae_pkg.sv]
// Shared types and constants of the matrix add, subtract and multiply engine.
package mae_pkg;

  localparam int DATA_W    = 32;
  localparam int DIM_REG_W = 4;
  localparam int OUT_IDX_W = 3;
  localparam int LOAD_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OPERATION = 3'd4;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_MUL  = 2'd2,
    OP_RSVD = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_CALC,
    ST_ACCUM,
    ST_EMIT,
    ST_ERR
  } state_t;

  // Controls from the sequencer to the shared arithmetic unit.
  typedef struct packed {
    logic calc;
    logic accum;
    logic first;
    op_t  op;
  } alu_ctl_t;

  // Request from the sequencer to load the output register.
  typedef struct packed {
    logic                 load;
    logic                 err;
    logic [OUT_IDX_W-1:0] row;
    logic [OUT_IDX_W-1:0] col;
    logic                 last;
  } out_ctl_t;

endpackage

[rtl/mae_store.sv]
// Element stores for matrix A and matrix B, one write and one registered read each.
module mae_store #(
  parameter int MAX_DIM = 8
) (
  input  logic                        clk,
  input  logic                        wr_en_a,
  input  logic                        wr_en_b,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] wr_addr,
  input  logic [mae_pkg::DATA_W-1:0]  wr_data,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] rd_addr_a,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] rd_addr_b,
  output logic [mae_pkg::DATA_W-1:0]  rd_data_a,
  output logic [mae_pkg::DATA_W-1:0]  rd_data_b
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;

  logic [mae_pkg::DATA_W-1:0] mem_a [DEPTH];
  logic [mae_pkg::DATA_W-1:0] mem_b [DEPTH];

  // Matrix A store.
  always_ff @(posedge clk) begin
    if (wr_en_a) begin
      mem_a[wr_addr] <= wr_data;
    end
    rd_data_a <= mem_a[rd_addr_a];
  end

  // Matrix B store.
  always_ff @(posedge clk) begin
    if (wr_en_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    rd_data_b <= mem_b[rd_addr_b];
  end

endmodule

[rtl/mae_alu.sv]
// Shared arithmetic unit: registered add, subtract or multiply, then accumulate.
module mae_alu (
  input  logic                       clk,
  input  mae_pkg::alu_ctl_t          ctl,
  input  logic [mae_pkg::DATA_W-1:0] a,
  input  logic [mae_pkg::DATA_W-1:0] b,
  output logic [mae_pkg::DATA_W-1:0] acc
);

  logic [mae_pkg::DATA_W-1:0] prod;

  // First stage: one operation on the two store words, wrapped to 32 bits.
  always_ff @(posedge clk) begin
    if (ctl.calc) begin
      case (ctl.op)
        mae_pkg::OP_ADD: prod <= a + b;
        mae_pkg::OP_SUB: prod <= a - b;
        mae_pkg::OP_MUL: prod <= a * b;
        default:         prod <= a + b;
      endcase
    end
  end

  // Second stage: start a new sum on the first term, otherwise add to it.
  always_ff @(posedge clk) begin
    if (ctl.accum) begin
      acc <= ctl.first ? prod : acc + prod;
    end
  end

endmodule

[rtl/mae_ctrl.sv]
// Sequencer: loads elements into the stores, then steps the shared unit over the result.
module mae_ctrl #(
  parameter int MAX_DIM = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [mae_pkg::DIM_REG_W-1:0]       rows_a,
  input  logic [mae_pkg::DIM_REG_W-1:0]       cols_a,
  input  logic [mae_pkg::DIM_REG_W-1:0]       rows_b,
  input  logic [mae_pkg::DIM_REG_W-1:0]       cols_b,
  input  mae_pkg::op_t                        operation,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                out_free,
  output logic                                wr_en_a,
  output logic                                wr_en_b,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  wr_addr,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  rd_addr_a,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  rd_addr_b,
  output mae_pkg::alu_ctl_t                   alu_ctl,
  output mae_pkg::out_ctl_t                   out_ctl
);

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SZ_W   = $clog2(DEPTH + 1);
  localparam int CMP_W  = (mae_pkg::LOAD_W > SZ_W + 1) ? mae_pkg::LOAD_W : SZ_W + 1;
  localparam int EW     = (DIM_W > mae_pkg::DIM_REG_W) ? DIM_W : mae_pkg::DIM_REG_W;
  localparam int OW     = (IDX_W > mae_pkg::OUT_IDX_W) ? IDX_W : mae_pkg::OUT_IDX_W;

  // A dimension of zero counts as one, any value above the maximum as the maximum.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [mae_pkg::DIM_REG_W-1:0] d);
    logic [EW-1:0] x;
    x = EW'(d);
    if (x == '0) return DIM_W'(1);
    if (x > EW'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return DIM_W'(x);
  endfunction

  mae_pkg::state_t state, state_next;

  logic [mae_pkg::LOAD_W-1:0] load_count;
  logic [mae_pkg::LOAD_W-1:0] lc_inc;
  logic [IDX_W-1:0]           i, j, k;

  logic [DIM_W-1:0] ra, ca, rb, cb, nc, kmax;
  logic [SZ_W-1:0]  size_a, size_b, addr_a_full, addr_b_full;
  logic [CMP_W-1:0] lc_ext, sa_ext, sb_ext, total, b_pos;
  logic [OW-1:0]    row_ext, col_ext;
  logic             is_mul, dims_bad, accept, run_start;
  logic             i_last, j_last, k_last;

  // Effective sizes and loop bounds from the current registers.
  always_comb begin
    ra = eff_dim(rows_a);
    ca = eff_dim(cols_a);
    rb = eff_dim(rows_b);
    cb = eff_dim(cols_b);
    size_a = SZ_W'(ra) * SZ_W'(ca);
    size_b = SZ_W'(rb) * SZ_W'(cb);
    lc_ext = CMP_W'(load_count);
    sa_ext = CMP_W'(size_a);
    sb_ext = CMP_W'(size_b);
    total  = sa_ext + sb_ext;
    b_pos  = lc_ext - sa_ext;
    lc_inc = load_count + mae_pkg::LOAD_W'(1);
    is_mul = (operation == mae_pkg::OP_MUL);
    case (operation)
      mae_pkg::OP_ADD,
      mae_pkg::OP_SUB: dims_bad = (ra != rb) || (ca != cb);
      mae_pkg::OP_MUL: dims_bad = (ca != rb);
      default:         dims_bad = 1'b1;
    endcase
    nc     = is_mul ? cb : ca;
    kmax   = is_mul ? ca : DIM_W'(1);
    i_last = (DIM_W'(i) == ra - DIM_W'(1));
    j_last = (DIM_W'(j) == nc - DIM_W'(1));
    k_last = (DIM_W'(k) == kmax - DIM_W'(1));
    // A is walked along row i, B down column j; add and subtract read both at (i, j).
    addr_a_full = SZ_W'(i) * SZ_W'(ca) + SZ_W'(is_mul ? k : j);
    addr_b_full = SZ_W'(is_mul ? k : i) * SZ_W'(cb) + SZ_W'(j);
    rd_addr_a   = addr_a_full[ADDR_W-1:0];
    rd_addr_b   = addr_b_full[ADDR_W-1:0];
    row_ext     = OW'(i);
    col_ext     = OW'(j);
  end

  assign accept    = in_valid && (state == mae_pkg::ST_LOAD);
  assign run_start = (CMP_W'(lc_inc) >= total);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mae_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state and per-state controls.
  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    wr_en_a       = 1'b0;
    wr_en_b       = 1'b0;
    wr_addr       = lc_ext[ADDR_W-1:0];
    alu_ctl.calc  = 1'b0;
    alu_ctl.accum = 1'b0;
    alu_ctl.first = (k == '0);
    alu_ctl.op    = operation;
    out_ctl.load  = 1'b0;
    out_ctl.err   = 1'b0;
    out_ctl.row   = row_ext[mae_pkg::OUT_IDX_W-1:0];
    out_ctl.col   = col_ext[mae_pkg::OUT_IDX_W-1:0];
    out_ctl.last  = i_last && j_last;
    case (state)
      mae_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (accept) begin
          // Positions past A go to B; positions past B are dropped.
          if (lc_ext < sa_ext) begin
            wr_en_a = 1'b1;
          end else if (b_pos < sb_ext) begin
            wr_en_b = 1'b1;
            wr_addr = b_pos[ADDR_W-1:0];
          end
          if (run_start) begin
            state_next = dims_bad ? mae_pkg::ST_ERR : mae_pkg::ST_READ;
          end
        end
      end
      mae_pkg::ST_READ: begin
        state_next = mae_pkg::ST_CALC;
      end
      mae_pkg::ST_CALC: begin
        alu_ctl.calc = 1'b1;
        state_next   = mae_pkg::ST_ACCUM;
      end
      mae_pkg::ST_ACCUM: begin
        alu_ctl.accum = 1'b1;
        state_next    = k_last ? mae_pkg::ST_EMIT : mae_pkg::ST_READ;
      end
      mae_pkg::ST_EMIT: begin
        if (out_free) begin
          out_ctl.load = 1'b1;
          state_next   = (i_last && j_last) ? mae_pkg::ST_LOAD : mae_pkg::ST_READ;
        end
      end
      mae_pkg::ST_ERR: begin
        out_ctl.row  = '0;
        out_ctl.col  = '0;
        out_ctl.last = 1'b1;
        out_ctl.err  = 1'b1;
        if (out_free) begin
          out_ctl.load = 1'b1;
          state_next   = mae_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = mae_pkg::ST_LOAD;
      end
    endcase
  end

  // Load counter and loop indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      i          <= '0;
      j          <= '0;
      k          <= '0;
    end else begin
      if (accept) begin
        load_count <= run_start ? '0 : lc_inc;
      end
      if (state == mae_pkg::ST_ACCUM && !k_last) begin
        k <= k + IDX_W'(1);
      end
      if (state == mae_pkg::ST_EMIT && out_free) begin
        k <= '0;
        if (j_last) begin
          j <= '0;
          i <= i_last ? '0 : i + IDX_W'(1);
        end else begin
          j <= j + IDX_W'(1);
        end
      end
    end
  end

endmodule

[rtl/matrix_add_sub_mul_engine.sv]
// Top level of the matrix add, subtract and multiply engine.
//
// Input channel: one signed 32-bit word per accepted element on element_value,
// all rows_a*cols_a elements of A in row-major order, then all of B. Loading
// takes one word per cycle. The word that completes B starts the operation.
// Output channel: one word per result element in row-major order with its
// row and column; last_result marks the final word of a run. Dimensions that
// do not suit the operation give one word with status 1, last_result set and
// value, row and column zero. Each term of a result element goes through the
// store read, operate and accumulate states of the shared unit, and an emit
// state then hands the element to the output register. in_ready is low from
// the last B word until the final result has been loaded into the output
// register. A stalled receiver holds the output word and pauses the sequencer
// before its next result. Synchronous reset clears the load count, the
// sequencer and the output valid, and sets all four dimensions to 8 and the
// operation to add; the stores are not cleared.
`include "assert_macros.svh"

module matrix_add_sub_mul_engine #(
  parameter int MAX_DIM = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [mae_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [mae_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [mae_pkg::DATA_W-1:0]   element_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mae_pkg::DATA_W-1:0]   result_value,
  output logic [mae_pkg::OUT_IDX_W-1:0]       result_row,
  output logic [mae_pkg::OUT_IDX_W-1:0]       result_col,
  output logic                                last_result,
  output logic                                status
);

  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

  logic [mae_pkg::DIM_REG_W-1:0] rows_a, cols_a, rows_b, cols_b;
  mae_pkg::op_t                  operation;

  logic                       wr_en_a, wr_en_b, out_free;
  logic [ADDR_W-1:0]          wr_addr, rd_addr_a, rd_addr_b;
  logic [mae_pkg::DATA_W-1:0] rd_data_a, rd_data_b, acc;
  mae_pkg::alu_ctl_t          alu_ctl;
  mae_pkg::out_ctl_t          out_ctl;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= mae_pkg::DIM_REG_W'(8);
      cols_a    <= mae_pkg::DIM_REG_W'(8);
      rows_b    <= mae_pkg::DIM_REG_W'(8);
      cols_b    <= mae_pkg::DIM_REG_W'(8);
      operation <= mae_pkg::OP_ADD;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        mae_pkg::REG_ROWS_A:    rows_a    <= cfg_wdata;
        mae_pkg::REG_COLS_A:    cols_a    <= cfg_wdata;
        mae_pkg::REG_ROWS_B:    rows_b    <= cfg_wdata;
        mae_pkg::REG_COLS_B:    cols_b    <= cfg_wdata;
        mae_pkg::REG_OPERATION: operation <= mae_pkg::op_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid || out_ready;

  mae_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .rows_a    (rows_a),
    .cols_a    (cols_a),
    .rows_b    (rows_b),
    .cols_b    (cols_b),
    .operation (operation),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_free  (out_free),
    .wr_en_a   (wr_en_a),
    .wr_en_b   (wr_en_b),
    .wr_addr   (wr_addr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .alu_ctl   (alu_ctl),
    .out_ctl   (out_ctl)
  );

  mae_store #(.MAX_DIM(MAX_DIM)) u_store (
    .clk       (clk),
    .wr_en_a   (wr_en_a),
    .wr_en_b   (wr_en_b),
    .wr_addr   (wr_addr),
    .wr_data   (element_value),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  mae_alu u_alu (
    .clk (clk),
    .ctl (alu_ctl),
    .a   (rd_data_a),
    .b   (rd_data_b),
    .acc (acc)
  );

  // Output word valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ctl.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output word payload.
  always_ff @(posedge clk) begin
    if (out_ctl.load) begin
      result_value <= out_ctl.err ? '0 : acc;
      result_row   <= out_ctl.row;
      result_col   <= out_ctl.col;
      last_result  <= out_ctl.last;
      status       <= out_ctl.err;
    end
  end

  // A pending output word is never overwritten.
  `ASSERT_IMPLIES(a_no_overwrite, clk, rst, out_ctl.load, !out_valid || out_ready)
  // No element is taken in the same cycle as a result is produced.
  `ASSERT_IMPLIES(a_load_or_emit, clk, rst, in_valid && in_ready, !out_ctl.load)
  // An error word is always the single, final word of its run, with zero value, row and column.
  `ASSERT_IMPLIES(a_err_word, clk, rst, out_valid && status,
                  last_result && result_value == '0 && result_row == '0 && result_col == '0)
  // Once the last result is loaded, the block is ready for the next run.
  `ASSERT_NEXT(a_ready_after_last, clk, rst, out_ctl.load && out_ctl.last, in_ready)

endmodule
